@@ rtl/core/gaps_pkg.sv @@
package gaps_pkg;

    localparam int GRID_ROWS = 16;
    localparam int GRID_COLS = 16;
    localparam int NCELLS    = GRID_ROWS * GRID_COLS;
    localparam int CELL_W    = 8;
    localparam int LEN_W     = 9;
    localparam int F_W       = 10;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] MARK_UNSEEN = 2'd0;
    localparam logic [1:0] MARK_OPEN   = 2'd1;
    localparam logic [1:0] MARK_CLOSED = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic       cell_blocked;
        logic [3:0] start_row;
        logic [3:0] start_col;
        logic [3:0] goal_row;
        logic [3:0] goal_col;
    } in_beat_t;

    typedef struct packed {
        logic       found;
        logic [8:0] path_length;
        logic [3:0] step_row;
        logic [3:0] step_col;
        logic       last;
    } out_beat_t;

    typedef enum logic [16:0] {
        ST_CLR     = 17'b1 << 0,
        ST_IDLE    = 17'b1 << 1,
        ST_MCLR    = 17'b1 << 2,
        ST_SEED    = 17'b1 << 3,
        ST_SCAN_A  = 17'b1 << 4,
        ST_SCAN_B  = 17'b1 << 5,
        ST_SCAN_C  = 17'b1 << 6,
        ST_SHIFT_A = 17'b1 << 7,
        ST_SHIFT_B = 17'b1 << 8,
        ST_CLOSE   = 17'b1 << 9,
        ST_GCUR    = 17'b1 << 10,
        ST_NB_A    = 17'b1 << 11,
        ST_NB_B    = 17'b1 << 12,
        ST_PATH_A  = 17'b1 << 13,
        ST_PATH_B  = 17'b1 << 14,
        ST_RD      = 17'b1 << 15,
        ST_RESP    = 17'b1 << 16
    } state_t;

    typedef struct packed {
        state_t state;
    } ctl_t;

    typedef struct packed {
        logic       idx_end;
        logic       cnt_zero;
        logic       scan_last;
        logic       shift_done;
        logic       is_goal;
        logic       nb_in;
        logic       dir_last;
        logic       walk_done;
        logic       rd_hit;
        logic       out_free;
        logic [1:0] cmd;
    } stat_t;

    function automatic logic signed [5:0] dir_dr(input logic [2:0] d);
        case (d)
            3'd2, 3'd4, 3'd5: dir_dr = -6'sd1;
            3'd3, 3'd6, 3'd7: dir_dr = 6'sd1;
            default:          dir_dr = 6'sd0;
        endcase
    endfunction

    function automatic logic signed [5:0] dir_dc(input logic [2:0] d);
        case (d)
            3'd0, 3'd4, 3'd6: dir_dc = -6'sd1;
            3'd1, 3'd5, 3'd7: dir_dc = 6'sd1;
            default:          dir_dc = 6'sd0;
        endcase
    endfunction

    function automatic logic [3:0] adiff(input logic [3:0] a, input logic [3:0] b);
        adiff = (a > b) ? a - b : b - a;
    endfunction

endpackage

@@ rtl/core/gaps_ctrl.sv @@
module gaps_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  gaps_pkg::stat_t st,
    output gaps_pkg::ctl_t  ctl
);

    gaps_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gaps_pkg::ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gaps_pkg::ST_CLR: begin
                if (st.idx_end) state_next = gaps_pkg::ST_IDLE;
            end
            gaps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (st.cmd)
                        gaps_pkg::CMD_SEARCH: state_next = gaps_pkg::ST_MCLR;
                        gaps_pkg::CMD_READ:
                            state_next = st.rd_hit ? gaps_pkg::ST_RD : gaps_pkg::ST_RESP;
                        default: state_next = gaps_pkg::ST_RESP;
                    endcase
                end
            end
            gaps_pkg::ST_MCLR: begin
                if (st.idx_end) state_next = gaps_pkg::ST_SEED;
            end
            gaps_pkg::ST_SEED:   state_next = gaps_pkg::ST_SCAN_A;
            gaps_pkg::ST_SCAN_A: begin
                state_next = st.cnt_zero ? gaps_pkg::ST_RESP : gaps_pkg::ST_SCAN_B;
            end
            gaps_pkg::ST_SCAN_B: state_next = gaps_pkg::ST_SCAN_C;
            gaps_pkg::ST_SCAN_C: begin
                state_next = st.scan_last ? gaps_pkg::ST_SHIFT_A : gaps_pkg::ST_SCAN_A;
            end
            gaps_pkg::ST_SHIFT_A: begin
                state_next = st.shift_done ? gaps_pkg::ST_CLOSE : gaps_pkg::ST_SHIFT_B;
            end
            gaps_pkg::ST_SHIFT_B: state_next = gaps_pkg::ST_SHIFT_A;
            gaps_pkg::ST_CLOSE: begin
                state_next = st.is_goal ? gaps_pkg::ST_PATH_A : gaps_pkg::ST_GCUR;
            end
            gaps_pkg::ST_GCUR:  state_next = gaps_pkg::ST_NB_A;
            gaps_pkg::ST_NB_A: begin
                if (st.nb_in) state_next = gaps_pkg::ST_NB_B;
                else if (st.dir_last) state_next = gaps_pkg::ST_SCAN_A;
            end
            gaps_pkg::ST_NB_B: begin
                state_next = st.dir_last ? gaps_pkg::ST_SCAN_A : gaps_pkg::ST_NB_A;
            end
            gaps_pkg::ST_PATH_A: begin
                state_next = st.walk_done ? gaps_pkg::ST_RESP : gaps_pkg::ST_PATH_B;
            end
            gaps_pkg::ST_PATH_B: state_next = gaps_pkg::ST_PATH_A;
            gaps_pkg::ST_RD:     state_next = gaps_pkg::ST_RESP;
            gaps_pkg::ST_RESP: begin
                if (st.out_free) state_next = gaps_pkg::ST_IDLE;
            end
            default: state_next = gaps_pkg::ST_CLR;
        endcase
    end

    assign ctl.state = state_reg;

endmodule

@@ rtl/core/gaps_dp.sv @@
module gaps_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  gaps_pkg::ctl_t      ctl,
    input  logic                s_valid,
    input  gaps_pkg::in_beat_t  s_data,
    input  logic                m_ready,
    output logic                m_valid,
    output gaps_pkg::out_beat_t m_data,
    output gaps_pkg::stat_t     st
);

    logic blk_mem [gaps_pkg::NCELLS];
    logic [1:0] mark_mem [gaps_pkg::NCELLS];
    logic [gaps_pkg::LEN_W-1:0] cost_mem [gaps_pkg::NCELLS];
    logic [2:0] par_mem [gaps_pkg::NCELLS];
    logic [gaps_pkg::CELL_W-1:0] ord_mem [gaps_pkg::NCELLS];
    logic [gaps_pkg::CELL_W-1:0] path_mem [gaps_pkg::NCELLS];

    logic blk_we, blk_wd, blk_q;
    logic [7:0] blk_wa, blk_ra;
    logic mark_we;
    logic [1:0] mark_wd, mark_q;
    logic [7:0] mark_wa, mark_ra;
    logic cost_we;
    logic [8:0] cost_wd, cost_q;
    logic [7:0] cost_wa, cost_ra;
    logic par_we;
    logic [2:0] par_wd, par_q;
    logic [7:0] par_wa, par_ra;
    logic ord_we;
    logic [7:0] ord_wa, ord_wd, ord_ra, ord_q;
    logic path_we;
    logic [7:0] path_wa, path_wd, path_ra, path_q;

    logic [8:0] idx_reg, cnt_reg, plen_reg, rptr_reg, g_reg;
    logic [9:0] best_reg;
    logic [7:0] bi_reg, cur_reg, scell_reg, nb_reg, walk_reg, start_reg, goal_reg;
    logic [2:0] dir_reg;
    logic [1:0] cmd_reg;
    logic hit_reg, last_reg, m_valid_reg;
    gaps_pkg::out_beat_t m_data_reg;

    logic acc, load, take, better;
    logic [9:0] f_val;
    logic signed [5:0] nr, nc, pr, pc;
    logic [7:0] nb_cell, prev_cell;
    logic [8:0] rptr_inc;

    always_ff @(posedge aclk) begin
        if (blk_we) blk_mem[blk_wa] <= blk_wd;
        blk_q <= blk_mem[blk_ra];
    end
    always_ff @(posedge aclk) begin
        if (mark_we) mark_mem[mark_wa] <= mark_wd;
        mark_q <= mark_mem[mark_ra];
    end
    always_ff @(posedge aclk) begin
        if (cost_we) cost_mem[cost_wa] <= cost_wd;
        cost_q <= cost_mem[cost_ra];
    end
    always_ff @(posedge aclk) begin
        if (par_we) par_mem[par_wa] <= par_wd;
        par_q <= par_mem[par_ra];
    end
    always_ff @(posedge aclk) begin
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        ord_q <= ord_mem[ord_ra];
    end
    always_ff @(posedge aclk) begin
        if (path_we) path_mem[path_wa] <= path_wd;
        path_q <= path_mem[path_ra];
    end

    assign acc = (ctl.state == gaps_pkg::ST_IDLE) && s_valid;
    assign st.out_free = !m_valid_reg || m_ready;
    assign load = (ctl.state == gaps_pkg::ST_RESP) && st.out_free;
    assign rptr_inc = rptr_reg + 9'd1;

    assign nr = $signed({2'b00, cur_reg[7:4]}) + gaps_pkg::dir_dr(dir_reg);
    assign nc = $signed({2'b00, cur_reg[3:0]}) + gaps_pkg::dir_dc(dir_reg);
    assign nb_cell = {nr[3:0], nc[3:0]};
    assign pr = $signed({2'b00, walk_reg[7:4]}) - gaps_pkg::dir_dr(par_q);
    assign pc = $signed({2'b00, walk_reg[3:0]}) - gaps_pkg::dir_dc(par_q);
    assign prev_cell = {pr[3:0], pc[3:0]};

    assign f_val = {1'b0, cost_q}
                 + {6'd0, gaps_pkg::adiff(scell_reg[7:4], goal_reg[7:4])}
                 + {6'd0, gaps_pkg::adiff(scell_reg[3:0], goal_reg[3:0])};
    assign better = (idx_reg == 9'd0) || (f_val < best_reg);
    assign take = !blk_q && (mark_q == gaps_pkg::MARK_UNSEEN) && !cnt_reg[8];

    assign st.idx_end    = idx_reg[7:0] == 8'hFF;
    assign st.cnt_zero   = cnt_reg == 9'd0;
    assign st.scan_last  = (idx_reg + 9'd1) == cnt_reg;
    assign st.shift_done = (idx_reg + 9'd1) >= cnt_reg;
    assign st.is_goal    = cur_reg == goal_reg;
    assign st.nb_in      = (nr[5:4] == 2'b00) && (nc[5:4] == 2'b00);
    assign st.dir_last   = dir_reg == 3'd7;
    assign st.walk_done  = (walk_reg == start_reg) || plen_reg[8];
    assign st.rd_hit     = rptr_reg < plen_reg;
    assign st.cmd        = s_data.cmd;

    always_comb begin
        blk_we = 1'b0; blk_wa = idx_reg[7:0]; blk_wd = 1'b0; blk_ra = nb_cell;
        mark_we = 1'b0; mark_wa = idx_reg[7:0]; mark_wd = gaps_pkg::MARK_UNSEEN;
        mark_ra = nb_cell;
        cost_we = 1'b0; cost_wa = nb_reg; cost_wd = g_reg + 9'd1; cost_ra = ord_q;
        par_we = 1'b0; par_wa = nb_reg; par_wd = dir_reg; par_ra = walk_reg;
        ord_we = 1'b0; ord_wa = idx_reg[7:0]; ord_wd = ord_q; ord_ra = idx_reg[7:0];
        path_we = 1'b0; path_wa = plen_reg[7:0]; path_wd = prev_cell;
        path_ra = 8'(plen_reg - rptr_reg);
        case (ctl.state)
            gaps_pkg::ST_CLR: begin
                blk_we = 1'b1;
            end
            gaps_pkg::ST_IDLE: begin
                if (acc && s_data.cmd == gaps_pkg::CMD_WRITE) begin
                    blk_we = 1'b1;
                    blk_wa = {s_data.cell_row, s_data.cell_col};
                    blk_wd = s_data.cell_blocked;
                end
            end
            gaps_pkg::ST_MCLR: begin
                mark_we = 1'b1;
            end
            gaps_pkg::ST_SEED: begin
                cost_we = 1'b1; cost_wa = start_reg; cost_wd = 9'd0;
                ord_we = 1'b1; ord_wa = 8'd0; ord_wd = start_reg;
                mark_we = 1'b1; mark_wa = start_reg; mark_wd = gaps_pkg::MARK_OPEN;
            end
            gaps_pkg::ST_SHIFT_A: begin
                ord_ra = 8'(idx_reg + 9'd1);
            end
            gaps_pkg::ST_SHIFT_B: begin
                ord_we = 1'b1;
            end
            gaps_pkg::ST_CLOSE: begin
                mark_we = 1'b1; mark_wa = cur_reg; mark_wd = gaps_pkg::MARK_CLOSED;
                cost_ra = cur_reg;
                path_we = st.is_goal; path_wa = 8'd0; path_wd = cur_reg;
            end
            gaps_pkg::ST_NB_B: begin
                if (take) begin
                    cost_we = 1'b1;
                    par_we = 1'b1;
                    mark_we = 1'b1; mark_wa = nb_reg; mark_wd = gaps_pkg::MARK_OPEN;
                    ord_we = 1'b1; ord_wa = cnt_reg[7:0]; ord_wd = nb_reg;
                end
            end
            gaps_pkg::ST_PATH_B: begin
                path_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            cnt_reg     <= '0;
            plen_reg    <= '0;
            rptr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctl.state)
                gaps_pkg::ST_CLR, gaps_pkg::ST_MCLR: begin
                    idx_reg <= idx_reg + 9'd1;
                end
                gaps_pkg::ST_IDLE: begin
                    if (acc) begin
                        cmd_reg  <= s_data.cmd;
                        hit_reg  <= 1'b0;
                        last_reg <= 1'b0;
                        case (s_data.cmd)
                            gaps_pkg::CMD_SEARCH: begin
                                start_reg <= {s_data.start_row, s_data.start_col};
                                goal_reg  <= {s_data.goal_row, s_data.goal_col};
                                idx_reg   <= '0;
                                cnt_reg   <= '0;
                                plen_reg  <= '0;
                                rptr_reg  <= '0;
                            end
                            gaps_pkg::CMD_READ: begin
                                last_reg <= 1'b1;
                                if (st.rd_hit) begin
                                    hit_reg  <= 1'b1;
                                    rptr_reg <= rptr_inc;
                                    last_reg <= rptr_inc >= plen_reg;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                gaps_pkg::ST_SEED: begin
                    cnt_reg <= 9'd1;
                    idx_reg <= '0;
                end
                gaps_pkg::ST_SCAN_B: begin
                    scell_reg <= ord_q;
                end
                gaps_pkg::ST_SCAN_C: begin
                    if (better) begin
                        best_reg <= f_val;
                        bi_reg   <= idx_reg[7:0];
                        cur_reg  <= scell_reg;
                    end
                    if (st.scan_last) begin
                        idx_reg <= better ? idx_reg : {1'b0, bi_reg};
                    end else begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                end
                gaps_pkg::ST_SHIFT_B: begin
                    idx_reg <= idx_reg + 9'd1;
                end
                gaps_pkg::ST_CLOSE: begin
                    cnt_reg  <= cnt_reg - 9'd1;
                    dir_reg  <= 3'd0;
                    walk_reg <= cur_reg;
                    if (st.is_goal) plen_reg <= 9'd1;
                end
                gaps_pkg::ST_GCUR: begin
                    g_reg   <= cost_q;
                    idx_reg <= '0;
                end
                gaps_pkg::ST_NB_A: begin
                    nb_reg <= nb_cell;
                    if (!st.nb_in) dir_reg <= dir_reg + 3'd1;
                end
                gaps_pkg::ST_NB_B: begin
                    if (take) cnt_reg <= cnt_reg + 9'd1;
                    dir_reg <= dir_reg + 3'd1;
                end
                gaps_pkg::ST_PATH_B: begin
                    walk_reg <= prev_cell;
                    plen_reg <= plen_reg + 9'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.found       <= plen_reg != 9'd0;
            m_data_reg.path_length <= plen_reg;
            m_data_reg.step_row    <= hit_reg ? path_q[7:4] : 4'd0;
            m_data_reg.step_col    <= hit_reg ? path_q[3:0] : 4'd0;
            m_data_reg.last        <= (cmd_reg == gaps_pkg::CMD_READ) && last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/grid_astar_path_search.sv @@
// Channel   Direction  Beat type              Handshake
// s_        in         gaps_pkg::in_beat_t    s_valid / s_ready
// m_        out        gaps_pkg::out_beat_t   m_valid / m_ready
//
// A map write or a path read passes through ST_RESP before returning to idle; s_ready is high only when idle.
// A search first sweeps the marks of all 256 cells, then for each popped cell scans the
// open entries, shifts the entries behind it and visits up to eight neighbors.
// After reset a sweep clears all 256 cells of the obstacle map before the first beat is taken.
// A result beat waits in the output register while the next input beat is accepted.
module grid_astar_path_search (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gaps_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gaps_pkg::out_beat_t m_data
);

    gaps_pkg::ctl_t  ctl;
    gaps_pkg::stat_t st;

    gaps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .st      (st),
        .ctl     (ctl)
    );

    gaps_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .s_valid (s_valid),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .st      (st)
    );

    assign s_ready = ctl.state == gaps_pkg::ST_IDLE;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a beat while busy");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.path_length <= 9'd256)
        else $error("path length out of range");

    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.found == (m_data.path_length != 9'd0))
        else $error("found flag disagrees with path length");

endmodule
